>>> design/der_ecdsa_sig_to_raw_rs_defines.svh
// Assertion macros shared by the checker of the DER to raw r||s converter.
// Depends on nothing; the asserting scope must provide clk_i and rst_ni.
`ifndef DER_ECDSA_SIG_TO_RAW_RS_DEFINES_SVH
`define DER_ECDSA_SIG_TO_RAW_RS_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define DSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds while reset is asserted.
`define DSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/dsr_pkg.sv
// Shared types and constants of the DER ECDSA signature to raw r||s converter.
// Depends on nothing.
package dsr_pkg;

  localparam int unsigned COORD_BYTES_DEF = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;
  localparam logic [8:0] MIN_TOTAL = 9'd8;
  localparam logic [8:0] COUNT_SAT = 9'd258;

  typedef enum logic [3:0] {
    STS_OK        = 4'd0,
    STS_SHORT     = 4'd1,
    STS_NO_SEQ    = 4'd2,
    STS_SEQ_LEN   = 4'd3,
    STS_R_TAG     = 4'd4,
    STS_R_LEN     = 4'd5,
    STS_S_TAG     = 4'd6,
    STS_S_LEN     = 4'd7,
    STS_TRAILING  = 4'd8,
    STS_TOO_LARGE = 4'd9
  } status_e;

  typedef struct packed {
    logic    accept;
    logic    load_seq_len;
    logic    load_elem;
    logic    take_r;
    logic    take_s;
    logic    fail;
    status_e fail_code;
    logic    finish;
    logic    emit_load;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic seq_tag_bad;
    logic int_tag_bad;
    logic r_len_bad;
    logic elem_last;
    logic no_room;
    logic s_len_bad;
    logic s_len_trail;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

>>> design/der_ecdsa_sig_to_raw_rs.sv
// Channel   Dir  tdata                               tlast
// s_axis    in   [7:0] der_byte                      last_byte
// m_axis    out  [7:0] raw_byte, [11:8] status       last_out (word 2*COORD_BYTES)
//
// One input word is taken per cycle while tvalid is high; the word that carries
// tlast is followed by the PH_FINISH state, in which the status is settled.
// Then 2*COORD_BYTES output words leave at one per cycle, paced by the
// registered read of the r and s RAMs and by m_axis_tready.
// Input is not taken during that emission.
// Reset is asynchronous and active low; a stall on m_axis holds the word.
//
// Top level of the DER ECDSA signature to raw r||s converter.
// Depends on dsr_pkg, dsr_ctrl, dsr_dp and dsr_ram.
module der_ecdsa_sig_to_raw_rs #(
  parameter int unsigned COORD_BYTES = dsr_pkg::COORD_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] der_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] raw_byte, [11:8] status
  output logic                            m_axis_tlast
);

  dsr_pkg::cmd_t    cmd;
  dsr_pkg::stat_t   stat;
  logic [7:0]       m_byte;
  dsr_pkg::status_e m_status;

  dsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  dsr_dp #(
    .COORD_BYTES (COORD_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .der_byte_i (s_axis_tdata),
    .m_ready_i  (m_axis_tready),
    .stat_o     (stat),
    .m_valid_o  (m_axis_tvalid),
    .m_byte_o   (m_byte),
    .m_status_o (m_status),
    .m_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, m_status, m_byte};

endmodule

>>> design/dsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dsr_ctrl.sv
// Parse and emission sequencer of the DER to raw r||s converter.
// Depends on dsr_pkg; drives the datapath through dsr_pkg::cmd_t.
module dsr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_last_i,
  input  dsr_pkg::stat_t  stat_i,
  output logic            s_ready_o,
  output dsr_pkg::cmd_t   cmd_o
);

  typedef enum logic [10:0] {
    PH_SEQ_TAG = 11'b000_0000_0001,
    PH_SEQ_LEN = 11'b000_0000_0010,
    PH_R_TAG   = 11'b000_0000_0100,
    PH_R_LEN   = 11'b000_0000_1000,
    PH_R_DATA  = 11'b000_0001_0000,
    PH_S_TAG   = 11'b000_0010_0000,
    PH_S_LEN   = 11'b000_0100_0000,
    PH_S_DATA  = 11'b000_1000_0000,
    PH_DONE    = 11'b001_0000_0000,
    PH_FINISH  = 11'b010_0000_0000,
    PH_EMIT    = 11'b100_0000_0000
  } phase_e;

  phase_e phase_q, phase_d;
  logic   parsing;
  logic   accept;

  assign parsing   = (phase_q != PH_FINISH) && (phase_q != PH_EMIT);
  assign accept    = parsing && s_valid_i;
  assign s_ready_o = parsing;

  always_comb begin
    phase_d      = phase_q;
    cmd_o        = '0;
    cmd_o.accept = accept;
    unique case (phase_q)
      PH_SEQ_TAG: begin
        if (accept) begin
          if (stat_i.seq_tag_bad) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_NO_SEQ;
            phase_d         = PH_DONE;
          end else begin
            phase_d = PH_SEQ_LEN;
          end
        end
      end
      PH_SEQ_LEN: begin
        if (accept) begin
          cmd_o.load_seq_len = 1'b1;
          phase_d            = PH_R_TAG;
        end
      end
      PH_R_TAG: begin
        if (accept) begin
          if (stat_i.int_tag_bad) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_R_TAG;
            phase_d         = PH_DONE;
          end else begin
            phase_d = PH_R_LEN;
          end
        end
      end
      PH_R_LEN: begin
        if (accept) begin
          if (stat_i.r_len_bad) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_R_LEN;
            phase_d         = PH_DONE;
          end else begin
            cmd_o.load_elem = 1'b1;
            phase_d         = PH_R_DATA;
          end
        end
      end
      PH_R_DATA: begin
        if (accept) begin
          cmd_o.take_r = 1'b1;
          if (stat_i.elem_last) begin
            if (stat_i.no_room) begin
              cmd_o.fail      = 1'b1;
              cmd_o.fail_code = dsr_pkg::STS_S_TAG;
              phase_d         = PH_DONE;
            end else begin
              phase_d = PH_S_TAG;
            end
          end
        end
      end
      PH_S_TAG: begin
        if (accept) begin
          priority if (stat_i.int_tag_bad) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_S_TAG;
            phase_d         = PH_DONE;
          end else if (stat_i.no_room) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_S_LEN;
            phase_d         = PH_DONE;
          end else begin
            phase_d = PH_S_LEN;
          end
        end
      end
      PH_S_LEN: begin
        if (accept) begin
          priority if (stat_i.s_len_bad) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_S_LEN;
            phase_d         = PH_DONE;
          end else if (stat_i.s_len_trail) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = dsr_pkg::STS_TRAILING;
            phase_d         = PH_DONE;
          end else begin
            cmd_o.load_elem = 1'b1;
            phase_d         = PH_S_DATA;
          end
        end
      end
      PH_S_DATA: begin
        if (accept) begin
          cmd_o.take_s = 1'b1;
          if (stat_i.elem_last) begin
            phase_d = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      PH_FINISH: begin
        cmd_o.finish = 1'b1;
        phase_d      = PH_EMIT;
      end
      PH_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_SEQ_TAG;
          end
        end
      end
      default: begin
        phase_d = PH_SEQ_TAG;
      end
    endcase
    if (accept && s_last_i) begin
      phase_d = PH_FINISH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEQ_TAG;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

>>> design/dsr_dp.sv
// Datapath of the DER to raw r||s converter: counters, checks, r and s stores,
// status and the output register. Depends on dsr_pkg and dsr_ram.
module dsr_dp #(
  parameter int unsigned COORD_BYTES = dsr_pkg::COORD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsr_pkg::cmd_t     cmd_i,
  input  logic [7:0]        der_byte_i,
  input  logic              m_ready_i,
  output dsr_pkg::stat_t    stat_o,
  output logic              m_valid_o,
  output logic [7:0]        m_byte_o,
  output dsr_pkg::status_e  m_status_o,
  output logic              m_last_o
);

  localparam int unsigned AW = $clog2(COORD_BYTES);
  localparam int unsigned CW = $clog2(COORD_BYTES + 2);
  localparam int unsigned IW = $clog2(2 * COORD_BYTES);
  localparam int unsigned SW = IW + 1;
  localparam logic [CW-1:0] CNT_FULL = CW'(COORD_BYTES);
  localparam logic [IW-1:0] IDX_S    = IW'(COORD_BYTES);
  localparam logic [IW-1:0] IDX_LAST = IW'(2 * COORD_BYTES - 1);
  localparam logic [SW-1:0] SUM_C    = SW'(COORD_BYTES);

  logic [8:0]        byte_count_q, byte_count_d;
  logic [7:0]        seq_len_q, seq_len_d;
  logic [7:0]        elem_q, elem_d;
  logic              slz_q, slz_d;
  logic [CW-1:0]     cnt_r_q, cnt_r_d;
  logic [CW-1:0]     cnt_s_q, cnt_s_d;
  dsr_pkg::status_e  err_q, err_d;
  dsr_pkg::status_e  status_q, status_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  dsr_pkg::status_e  out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic [8:0]        total;
  logic [9:0]        total_w;
  logic [9:0]        idx1;
  logic [9:0]        s_sum;
  logic              digit;
  logic              r_we, s_we;
  logic              rd_en;
  logic [IW-1:0]     nidx;
  logic [IW-1:0]     n_pos;
  logic [SW-1:0]     r_addr_sum, s_addr_sum;
  logic [7:0]        r_rdata, s_rdata;
  logic              is_s;
  logic [IW-1:0]     pos;
  logic [CW-1:0]     cnt_sel;
  logic              in_range;
  logic [7:0]        emit_byte;

  assign total   = {1'b0, seq_len_q} + 9'd2;
  assign total_w = {1'b0, total};
  assign idx1    = {1'b0, byte_count_q} + 10'd1;
  assign s_sum   = idx1 + {2'b00, der_byte_i};
  assign digit   = !(slz_q && (der_byte_i == 8'h00));

  assign stat_o.seq_tag_bad = der_byte_i != dsr_pkg::SEQ_TAG;
  assign stat_o.int_tag_bad = der_byte_i != dsr_pkg::INT_TAG;
  assign stat_o.r_len_bad   = (der_byte_i == 8'h00) ||
                              (({2'b00, der_byte_i} + 10'd4) > total_w);
  assign stat_o.elem_last   = elem_q == 8'd1;
  assign stat_o.no_room     = idx1 >= total_w;
  assign stat_o.s_len_bad   = (der_byte_i == 8'h00) || (s_sum > total_w);
  assign stat_o.s_len_trail = s_sum != total_w;
  assign stat_o.out_free    = !out_valid_q || m_ready_i;
  assign stat_o.emit_last   = idx_q == IDX_LAST;

  assign r_we = cmd_i.take_r && digit && (cnt_r_q < CNT_FULL);
  assign s_we = cmd_i.take_s && digit && (cnt_s_q < CNT_FULL);

  // Read address for the next byte to emit: position inside its half plus
  // the fill count, minus the coordinate width.
  assign rd_en      = cmd_i.finish || cmd_i.emit_load;
  assign nidx       = cmd_i.finish ? '0 : idx_q + 1'b1;
  assign n_pos      = (nidx >= IDX_S) ? nidx - IDX_S : nidx;
  assign r_addr_sum = SW'(n_pos) + SW'(cnt_r_q) - SUM_C;
  assign s_addr_sum = SW'(n_pos) + SW'(cnt_s_q) - SUM_C;

  dsr_ram #(
    .WIDTH (8),
    .DEPTH (COORD_BYTES)
  ) u_r_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (cnt_r_q[AW-1:0]),
    .wdata_i (der_byte_i),
    .re_i    (rd_en),
    .raddr_i (r_addr_sum[AW-1:0]),
    .rdata_o (r_rdata)
  );

  dsr_ram #(
    .WIDTH (8),
    .DEPTH (COORD_BYTES)
  ) u_s_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (cnt_s_q[AW-1:0]),
    .wdata_i (der_byte_i),
    .re_i    (rd_en),
    .raddr_i (s_addr_sum[AW-1:0]),
    .rdata_o (s_rdata)
  );

  assign is_s      = idx_q >= IDX_S;
  assign pos       = is_s ? idx_q - IDX_S : idx_q;
  assign cnt_sel   = is_s ? cnt_s_q : cnt_r_q;
  assign in_range  = (SW'(pos) + SW'(cnt_sel)) >= SUM_C;
  assign emit_byte = ((status_q == dsr_pkg::STS_OK) && in_range) ?
                     (is_s ? s_rdata : r_rdata) : 8'h00;

  always_comb begin
    byte_count_d = byte_count_q;
    seq_len_d    = seq_len_q;
    elem_d       = elem_q;
    slz_d        = slz_q;
    cnt_r_d      = cnt_r_q;
    cnt_s_d      = cnt_s_q;
    err_d        = err_q;
    status_d     = status_q;
    idx_d        = idx_q;

    if (cmd_i.accept && (byte_count_q < dsr_pkg::COUNT_SAT)) begin
      byte_count_d = byte_count_q + 9'd1;
    end
    if (cmd_i.load_seq_len) begin
      seq_len_d = der_byte_i;
    end
    if (cmd_i.load_elem) begin
      elem_d = der_byte_i;
      slz_d  = 1'b1;
    end
    if (cmd_i.take_r || cmd_i.take_s) begin
      elem_d = elem_q - 8'd1;
      if (digit) begin
        slz_d = 1'b0;
      end
    end
    if (cmd_i.take_r && digit && (cnt_r_q <= CNT_FULL)) begin
      cnt_r_d = cnt_r_q + 1'b1;
    end
    if (cmd_i.take_s && digit && (cnt_s_q <= CNT_FULL)) begin
      cnt_s_d = cnt_s_q + 1'b1;
    end
    if (cmd_i.fail) begin
      err_d = cmd_i.fail_code;
    end

    if (cmd_i.finish) begin
      idx_d = '0;
      priority if (byte_count_q < dsr_pkg::MIN_TOTAL) begin
        status_d = dsr_pkg::STS_SHORT;
      end else if (err_q == dsr_pkg::STS_NO_SEQ) begin
        status_d = dsr_pkg::STS_NO_SEQ;
      end else if (total != byte_count_q) begin
        status_d = dsr_pkg::STS_SEQ_LEN;
      end else if (err_q != dsr_pkg::STS_OK) begin
        status_d = err_q;
      end else if ((cnt_r_q > CNT_FULL) || (cnt_s_q > CNT_FULL)) begin
        status_d = dsr_pkg::STS_TOO_LARGE;
      end else begin
        status_d = dsr_pkg::STS_OK;
      end
    end
    if (cmd_i.emit_load) begin
      idx_d = idx_q + 1'b1;
    end

    if (cmd_i.clear) begin
      byte_count_d = '0;
      seq_len_d    = '0;
      elem_d       = '0;
      slz_d        = 1'b1;
      cnt_r_d      = '0;
      cnt_s_d      = '0;
      err_d        = dsr_pkg::STS_OK;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (cmd_i.emit_load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = emit_byte;
      out_status_d = status_q;
      out_last_d   = idx_q == IDX_LAST;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      seq_len_q    <= '0;
      elem_q       <= '0;
      slz_q        <= 1'b1;
      cnt_r_q      <= '0;
      cnt_s_q      <= '0;
      err_q        <= dsr_pkg::STS_OK;
      status_q     <= dsr_pkg::STS_OK;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      seq_len_q    <= seq_len_d;
      elem_q       <= elem_d;
      slz_q        <= slz_d;
      cnt_r_q      <= cnt_r_d;
      cnt_s_q      <= cnt_s_d;
      err_q        <= err_d;
      status_q     <= status_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_byte_o   = out_byte_q;
  assign m_status_o = out_status_q;
  assign m_last_o   = out_last_q;

endmodule

>>> design/dsr_checker.sv
// Port-level checker of the DER to raw r||s converter, bound to its top level.
// Depends on dsr_pkg and der_ecdsa_sig_to_raw_rs_defines.svh.
`include "der_ecdsa_sig_to_raw_rs_defines.svh"

module dsr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  `DSR_ASSERT_RST(a_no_word_in_reset, !rst_ni |-> !m_axis_tvalid, "output word during reset")

  `DSR_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

  `DSR_ASSERT(a_error_zero, m_axis_tvalid && (m_axis_tdata[11:8] != dsr_pkg::STS_OK) |-> (m_axis_tdata[7:0] == 8'h00) && (m_axis_tdata[11:8] <= dsr_pkg::STS_TOO_LARGE), "bad status or nonzero byte on error")

  `DSR_ASSERT(a_no_input_while_emitting, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input taken during emission")

endmodule

bind der_ecdsa_sig_to_raw_rs dsr_checker u_dsr_checker (.*);
